/* design/dsa_pkg.sv */
// Shared types, constants and track/sector helper functions for the sector allocator.
`timescale 1ns / 1ps
package dsa_pkg;

  localparam int MaxTracks  = 42;
  localparam int MaxSectors = 21;
  localparam int TrkW       = 6;
  localparam int SecW       = 5;
  localparam int RowW       = MaxSectors;
  localparam int AddrW      = $clog2(MaxTracks);
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 5;

  localparam logic [TrkW-1:0] DirTrack = TrkW'(18);
  localparam logic [4:0]      IntlvRst = 5'd10;

  typedef enum logic [1:0] {
    OpAllocFirst = 2'd0,
    OpAllocNext  = 2'd1,
    OpFree       = 2'd2,
    OpMark       = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTrackOrder  = 3'd0,
    CfgTrackLimit  = 3'd1,
    CfgFilesOnDir  = 3'd2,
    CfgPreferDir   = 3'd3,
    CfgSimpleIntlv = 3'd4,
    CfgChainIntlv  = 3'd5,
    CfgFileIntlv   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StReduce,
    StRead,
    StCheck
  } state_e;

  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [RowW-1:0]  wr_data;
  } map_req_t;

  // Zone table, capped at the sector maximum.
  function automatic logic [SecW-1:0] sectors_of(input logic [TrkW-1:0] t);
    logic [SecW-1:0] n;
    if (t == '0 || t > TrkW'(MaxTracks)) begin
      n = '0;
    end else if (t <= TrkW'(17)) begin
      n = SecW'(21);
    end else if (t <= TrkW'(24)) begin
      n = SecW'(19);
    end else if (t <= TrkW'(30)) begin
      n = SecW'(18);
    end else begin
      n = SecW'(17);
    end
    if (n > SecW'(MaxSectors)) begin
      n = SecW'(MaxSectors);
    end
    return n;
  endfunction

  function automatic logic [TrkW-1:0] limit_tracks(input logic [1:0] lim);
    logic [TrkW-1:0] r;
    case (lim)
      2'd0:    r = TrkW'(35);
      2'd1:    r = TrkW'(40);
      default: r = TrkW'(42);
    endcase
    return r;
  endfunction

  function automatic logic [TrkW-1:0] next_track(input logic [TrkW-1:0] t,
                                                 input logic [1:0] order,
                                                 input logic [1:0] lim,
                                                 input logic fod,
                                                 input logic pref);
    logic has40, has42, ok_np, dpref;
    logic [TrkW-1:0] r;
    has40 = (lim >= 2'd1);
    has42 = (lim >= 2'd2);
    ok_np = fod & ~pref;
    dpref = fod & pref;
    r = '0;
    if (t == '0 || t > TrkW'(42)) begin
      r = '0;
    end else if (order == 2'd1) begin
      if (t >= TrkW'(40) && !has42)      r = '0;
      else if (t >= TrkW'(35) && !has40) r = '0;
      else if (t >= TrkW'(42))           r = '0;
      else if (t == TrkW'(17))           r = ok_np ? DirTrack : TrkW'(19);
      else if (t == DirTrack && dpref)   r = TrkW'(1);
      else                               r = TrkW'(t + TrkW'(1));
    end else if (order == 2'd2) begin
      if (t == TrkW'(42))                            r = ok_np ? DirTrack : '0;
      else if (t == TrkW'(40) || (t == TrkW'(35) && !has40)) r = TrkW'(1);
      else if (t == TrkW'(17))                       r = has42 ? TrkW'(41) :
                                                         (ok_np ? DirTrack : '0);
      else if (t == DirTrack)                        r = dpref ? TrkW'(19) : '0;
      else                                           r = TrkW'(t + TrkW'(1));
    end else begin
      if (t >= TrkW'(40) && !has42)      r = '0;
      else if (t >= TrkW'(35) && !has40) r = '0;
      else if (t >= TrkW'(42))           r = '0;
      else if (t == TrkW'(1))            r = '0;
      else if (t == DirTrack)            r = dpref ? TrkW'(17) : '0;
      else if (t < DirTrack)             r = TrkW'(t - TrkW'(1));
      else                               r = TrkW'(t + TrkW'(1));
    end
    return r;
  endfunction

  function automatic logic [TrkW-1:0] start_track(input logic [TrkW-1:0] t,
                                                  input logic [1:0] order,
                                                  input logic [1:0] lim,
                                                  input logic fod,
                                                  input logic pref);
    logic [TrkW-1:0] r;
    if (t == '0) begin
      if (fod && pref)        r = DirTrack;
      else if (order == 2'd1) r = TrkW'(1);
      else if (order == 2'd2) r = TrkW'(19);
      else                    r = TrkW'(17);
    end else if (order == 2'd1 || order == 2'd2) begin
      r = next_track(t, order, lim, fod, pref);
    end else if (t >= TrkW'(40) && lim < 2'd2) begin
      r = '0;
    end else if (t >= TrkW'(35)) begin
      if (lim < 2'd1)               r = '0;
      else if (t >= TrkW'(42))      r = '0;
      else                          r = TrkW'(t + TrkW'(1));
    end else if (t == DirTrack) begin
      r = TrkW'(17);
    end else if (t < DirTrack) begin
      r = TrkW'(TrkW'(36) - t);
    end else begin
      r = TrkW'(TrkW'(35) - t);
    end
    return r;
  endfunction

  // First step of the start-sector rule; the remaining wrap is done by repeated subtract.
  function automatic logic [8:0] init_sec(input logic [7:0] sect,
                                          input logic [4:0] il,
                                          input logic simple,
                                          input logic [SecW-1:0] n);
    logic [8:0] sum;
    logic [7:0] s8;
    sum = 9'(sect) + 9'(il);
    s8  = sum[7:0];
    if (il == '0) begin
      return '0;
    end
    if (simple) begin
      return sum;
    end
    if (s8 >= 8'(n)) begin
      s8 = 8'(s8 - 8'(n));
      if (s8 != '0) begin
        s8 = 8'(s8 - 8'd1);
      end
    end
    return 9'(s8);
  endfunction

endpackage

/* design/dsa_map.sv */
// Sector bitmap memory: one row per track, valid bits give the reset image.
`timescale 1ns / 1ps
module dsa_map (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dsa_pkg::map_req_t         req_i,
  output logic [dsa_pkg::RowW-1:0]  rd_data_o
);
  import dsa_pkg::*;

  logic [RowW-1:0]      mem_q [MaxTracks];
  logic [MaxTracks-1:0] vld_q;
  logic [RowW-1:0]      rd_q;
  logic                 rd_vld_q;
  logic [AddrW-1:0]     rd_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.wr_en) begin
      vld_q[req_i.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q      <= mem_q[req_i.rd_addr];
      rd_vld_q  <= vld_q[req_i.rd_addr];
      rd_addr_q <= req_i.rd_addr;
    end
  end

  // An unwritten row reads as its reset image: only the directory header is used.
  always_comb begin
    if (rd_vld_q) begin
      rd_data_o = rd_q;
    end else if (rd_addr_q == AddrW'(DirTrack - TrkW'(1))) begin
      rd_data_o = RowW'(1);
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

/* design/dsa_scan.sv */
// Sector finder: first free sector at or after a start point, wrapping.
`timescale 1ns / 1ps
module dsa_scan (
  input  logic [dsa_pkg::RowW-1:0] row_i,
  input  logic [dsa_pkg::SecW-1:0] count_i,
  input  logic [dsa_pkg::SecW-1:0] from_i,
  output logic                     found_o,
  output logic [dsa_pkg::SecW-1:0] idx_o
);
  import dsa_pkg::*;

  logic [RowW-1:0] free_w;
  logic [RowW-1:0] hi_w;
  logic [SecW-1:0] hi_idx;
  logic [SecW-1:0] any_idx;

  always_comb begin
    for (int i = 0; i < RowW; i++) begin
      free_w[i] = ~row_i[i] && (SecW'(i) < count_i);
      hi_w[i]   = free_w[i] && (SecW'(i) >= from_i);
    end
    hi_idx  = '0;
    any_idx = '0;
    for (int i = RowW - 1; i >= 0; i--) begin
      if (hi_w[i]) begin
        hi_idx = SecW'(i);
      end
      if (free_w[i]) begin
        any_idx = SecW'(i);
      end
    end
    found_o = |free_w;
    idx_o   = (|hi_w) ? hi_idx : any_idx;
  end

endmodule

/* design/disk_sector_allocator.sv */
// Sector allocator top level: config registers, sequencer, bitmap and sector finder.
// Free and mark: the sequencer goes through StRead and StCheck and done_o is registered from
// StCheck (straight from idle if the target is out of range). Allocation visits tracks in order;
// each track takes a bitmap read (StRead) and a sector-finder check (StCheck), plus the
// start-sector reduction steps (StReduce) in allocate-next mode. One item at a time; busy is
// high until the result is out. Reset is asynchronous: config and sequencer state registers go
// to defaults (result registers are not reset) and the bitmap reads as all free but 18/0.
`timescale 1ns / 1ps
module disk_sector_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation_i,
  input  logic [dsa_pkg::TrkW-1:0]      track_i,
  input  logic [dsa_pkg::SecW-1:0]      sector_i,
  output logic                          done_o,
  output logic [dsa_pkg::TrkW-1:0]      result_track_o,
  output logic [dsa_pkg::SecW-1:0]      result_sector_o,
  output logic                          status_o,
  input  logic                          cfg_we_i,
  input  logic [dsa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dsa_pkg::CfgDataW-1:0]  cfg_data_i
);
  import dsa_pkg::*;

  logic [1:0] order_q, limit_q;
  logic       fod_q, pref_q, simp_q, chain_q;
  logic [4:0] intlv_q;

  state_e          state_q, state_d;
  op_e             op_q, op_d;
  logic            next_mode_q, next_mode_d;
  logic [TrkW-1:0] trk_q, trk_d;
  logic [8:0]      sec_q, sec_d;
  logic            done_q, done_d;
  logic [TrkW-1:0] rtrk_q, rtrk_d;
  logic [SecW-1:0] rsec_q, rsec_d;
  logic            stat_q, stat_d;

  map_req_t        req;
  logic [RowW-1:0] row;
  logic [SecW-1:0] n_cur;
  logic            found;
  logic [SecW-1:0] idx;
  logic [TrkW-1:0] tn;
  logic [TrkW-1:0] first_trk;
  logic            in_ok;
  logic [RowW-1:0] bit_hit;
  logic [RowW-1:0] bit_tgt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= '0;
      limit_q <= '0;
      fod_q   <= 1'b0;
      pref_q  <= 1'b0;
      simp_q  <= 1'b0;
      chain_q <= 1'b0;
      intlv_q <= IntlvRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgTrackOrder:  order_q <= cfg_data_i[1:0];
        CfgTrackLimit:  limit_q <= cfg_data_i[1:0];
        CfgFilesOnDir:  fod_q   <= cfg_data_i[0];
        CfgPreferDir:   pref_q  <= cfg_data_i[0];
        CfgSimpleIntlv: simp_q  <= cfg_data_i[0];
        CfgChainIntlv:  chain_q <= cfg_data_i[0];
        CfgFileIntlv:   intlv_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dsa_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_data_o (row)
  );

  dsa_scan u_scan (
    .row_i   (row),
    .count_i (n_cur),
    .from_i  (sec_q[SecW-1:0]),
    .found_o (found),
    .idx_o   (idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      done_q      <= 1'b0;
      op_q        <= OpAllocFirst;
      next_mode_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      op_q        <= op_d;
      next_mode_q <= next_mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    trk_q  <= trk_d;
    sec_q  <= sec_d;
    rtrk_q <= rtrk_d;
    rsec_q <= rsec_d;
    stat_q <= stat_d;
  end

  always_comb begin
    n_cur     = sectors_of(trk_q);
    first_trk = start_track('0, order_q, limit_q, fod_q, pref_q);
    in_ok     = (track_i >= TrkW'(1)) && (track_i <= limit_tracks(limit_q)) &&
                (track_i <= TrkW'(MaxTracks));
    tn        = next_mode_q ? next_track(trk_q, order_q, limit_q, fod_q, pref_q)
                            : start_track(trk_q, order_q, limit_q, fod_q, pref_q);
    bit_hit   = RowW'(1) << idx;
    bit_tgt   = RowW'(1) << sec_q[SecW-1:0];

    state_d     = state_q;
    op_d        = op_q;
    next_mode_d = next_mode_q;
    trk_d       = trk_q;
    sec_d       = sec_q;
    done_d      = 1'b0;
    rtrk_d      = rtrk_q;
    rsec_d      = rsec_q;
    stat_d      = stat_q;
    req         = '0;

    case (state_q)
      StIdle: begin
        if (start) begin
          op_d = op_e'(operation_i);
          if (op_e'(operation_i) == OpFree || op_e'(operation_i) == OpMark) begin
            if (in_ok && sector_i < sectors_of(track_i)) begin
              trk_d   = track_i;
              sec_d   = 9'(sector_i);
              state_d = StRead;
            end else begin
              done_d = 1'b1;
              rtrk_d = '0;
              rsec_d = '0;
              stat_d = 1'b0;
            end
          end else if (op_e'(operation_i) == OpAllocNext && in_ok) begin
            next_mode_d = 1'b1;
            trk_d       = track_i;
            sec_d       = init_sec(8'(sector_i), intlv_q, simp_q, sectors_of(track_i));
            state_d     = StReduce;
          end else begin
            next_mode_d = 1'b0;
            trk_d       = first_trk;
            sec_d       = '0;
            state_d     = StRead;
          end
        end
      end
      StReduce: begin
        // Wrap the start sector into the track one subtract at a time.
        if (n_cur != '0 && sec_q >= 9'(n_cur)) begin
          sec_d = 9'(sec_q - 9'(n_cur));
        end else begin
          state_d = StRead;
        end
      end
      StRead: begin
        req.rd_en   = 1'b1;
        req.rd_addr = AddrW'(trk_q - TrkW'(1));
        state_d     = StCheck;
      end
      StCheck: begin
        req.wr_addr = AddrW'(trk_q - TrkW'(1));
        if (op_q == OpFree || op_q == OpMark) begin
          req.wr_en = 1'b1;
          if (op_q == OpMark) begin
            req.wr_data = row | bit_tgt;
          end else if (trk_q == DirTrack && sec_q == '0) begin
            req.wr_data = row;
          end else begin
            req.wr_data = row & ~bit_tgt;
          end
          done_d  = 1'b1;
          rtrk_d  = '0;
          rsec_d  = '0;
          stat_d  = 1'b0;
          state_d = StIdle;
        end else if (found) begin
          req.wr_en   = 1'b1;
          req.wr_data = row | bit_hit;
          done_d      = 1'b1;
          rtrk_d      = trk_q;
          rsec_d      = idx;
          stat_d      = 1'b0;
          state_d     = StIdle;
        end else if (next_mode_q) begin
          if (tn == '0) begin
            // Chain ran out: fall back to a full search.
            next_mode_d = 1'b0;
            trk_d       = first_trk;
            sec_d       = '0;
            state_d     = StRead;
          end else if (chain_q) begin
            trk_d   = tn;
            sec_d   = init_sec(8'hff, intlv_q, simp_q, sectors_of(tn));
            state_d = StReduce;
          end else begin
            trk_d   = tn;
            sec_d   = '0;
            state_d = StRead;
          end
        end else if (tn == '0) begin
          done_d  = 1'b1;
          rtrk_d  = '0;
          rsec_d  = '0;
          stat_d  = 1'b1;
          state_d = StIdle;
        end else begin
          trk_d   = tn;
          sec_d   = '0;
          state_d = StRead;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy            = (state_q != StIdle);
  assign done_o          = done_q;
  assign result_track_o  = rtrk_q;
  assign result_sector_o = rsec_q;
  assign status_o        = stat_q;

  a_full_no_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o |-> result_track_o == '0 && result_sector_o == '0)
    else $error("disk full result carries a track");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_ok_track_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !status_o && result_track_o != '0 |->
      result_track_o <= TrkW'(MaxTracks) && result_sector_o < sectors_of(result_track_o))
    else $error("allocated sector outside the disk");

  a_write_in_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.wr_en |-> state_q == StCheck && !req.rd_en)
    else $error("bitmap write outside the check step");

endmodule
